### rtl/lbrt_pkg.sv
// shared types, constants and display helpers for the longest bit run tracker
// no dependencies; used by lbrt_run_len and longest_bit_run_tracker_unit
package lbrt_pkg;

    // width of the word port and of each run count field
    localparam int IN_W  = 32;
    localparam int RUN_W = 6;
    localparam int SEG_W = 8;
    localparam int DISP_W = 2 * SEG_W;

    typedef logic [RUN_W-1:0]  t_run;
    typedef logic [SEG_W-1:0]  t_seg;
    typedef logic [DISP_W-1:0] t_disp;

    // seven-segment patterns, digits 0 to 9
    localparam t_seg SEG_CODE [10] = '{
        8'b0011_1111, 8'b0000_0110, 8'b0101_1011, 8'b0100_1111, 8'b0110_0110,
        8'b0110_1101, 8'b0111_1101, 8'b0000_0111, 8'b0111_1111, 8'b0110_0111
    };

    localparam t_run DECADE = t_run'(10);

    // two-digit display word: tens pattern in the upper byte, units in the lower
    function automatic t_disp disp_word(input t_run v);
        logic [2:0] tens;
        t_run       tens_x10;
        t_run       units;
        priority if (v >= t_run'(60)) tens = 3'd6;
        else if (v >= t_run'(50))     tens = 3'd5;
        else if (v >= t_run'(40))     tens = 3'd4;
        else if (v >= t_run'(30))     tens = 3'd3;
        else if (v >= t_run'(20))     tens = 3'd2;
        else if (v >= DECADE)         tens = 3'd1;
        else                          tens = 3'd0;
        tens_x10 = t_run'({3'd0, tens} * DECADE);
        units    = v - tens_x10;
        return {SEG_CODE[{1'b0, tens}], SEG_CODE[units[3:0]]};
    endfunction

endpackage

### rtl/lbrt_run_len.sv
// longest run of one bits in a vector, log-depth and-of-shifts network
// depends on lbrt_pkg for the count width
module lbrt_run_len #(
    parameter int WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0]     i_vec,
    output logic [lbrt_pkg::RUN_W-1:0] o_len
);

    localparam int CW = lbrt_pkg::RUN_W + 1;

    // largest power of two strictly below n (n >= 2)
    function automatic int pow2_below(input int n);
        int p;
        p = 1;
        while (p * 2 < n) p = p * 2;
        return p;
    endfunction

    // run_at[g][i] set when bits i down to i-g are all one
    logic [WORD_BITS-1:0] run_at [WORD_BITS];
    logic [WORD_BITS-1:0] hit;
    logic [WORD_BITS-1:0] hit_up;
    logic [WORD_BITS-1:0] top_len;
    logic [CW-1:0]        cnt;

    assign run_at[0] = i_vec;

    for (genvar g = 1; g < WORD_BITS; g++) begin : g_len
        localparam int L = g + 1;
        localparam int P = pow2_below(L);
        assign run_at[g] = run_at[P-1] & (run_at[L-P-1] << P);
    end

    for (genvar g = 0; g < WORD_BITS; g++) begin : g_hit
        assign hit[g] = |run_at[g];
    end

    // hit is a thermometer; its top edge marks the longest run
    assign hit_up  = {1'b0, hit[WORD_BITS-1:1]};
    assign top_len = hit & ~hit_up;

    always_comb begin
        cnt = '0;
        for (int g = 0; g < WORD_BITS; g++) begin
            if (top_len[g]) begin
                cnt = cnt | CW'(g + 1);
            end
        end
    end

    // saturate a full 64-bit run to the field maximum
    assign o_len = cnt[CW-1] ? '1 : cnt[CW-2:0];

endmodule

### rtl/longest_bit_run_tracker_unit.sv
// top level of the longest bit run tracker: input stage, run measures,
// running maxima and result register; depends on lbrt_pkg and lbrt_run_len
//
// The block takes a stream of words, the final word of each set flagged by
// i_last. For every word it measures the longest run of ones, the longest
// run of zeros and the longest run of ones in word xor (word << 1), and keeps
// the running maximum of each. The final word of a set yields one result
// item holding the three maxima and their two-digit seven-segment display
// words, after which the maxima start again from zero. Only the low
// WORD_BITS bits of a word take part (bits above the 32-bit port read as
// zero); a run of 64 reports as 63. One item is accepted every clock cycle
// while no last word waits in the input register: an item sits in the
// input register while the run networks and the max compare work on it,
// and a last word's result enters the output register at the edge on
// which that word leaves the input register. Words that are not last pass
// through regardless of the output side; a last word waits in the input
// register only while a previous result is still untaken.
module longest_bit_run_tracker_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lbrt_pkg::IN_W-1:0]   i_word,
    input  logic                        i_last,
    // result channel
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lbrt_pkg::RUN_W-1:0]  o_max_ones,
    output logic [lbrt_pkg::RUN_W-1:0]  o_max_zeros,
    output logic [lbrt_pkg::RUN_W-1:0]  o_max_alternating,
    output logic [2*lbrt_pkg::DISP_W-1:0] o_display_pair,
    output logic [lbrt_pkg::DISP_W-1:0] o_display_alt
);

    // input stage
    logic                  r_in_valid, n_in_valid;
    logic                  r_in_last;
    logic [WORD_BITS-1:0]  r_in_word;
    logic [WORD_BITS-1:0]  w_ext;

    // running maxima
    lbrt_pkg::t_run r_best_ones, n_best_ones;
    lbrt_pkg::t_run r_best_zeros, n_best_zeros;
    lbrt_pkg::t_run r_best_alt, n_best_alt;

    // result register
    logic           r_out_valid, n_out_valid;
    lbrt_pkg::t_run r_out_ones;
    lbrt_pkg::t_run r_out_zeros;
    lbrt_pkg::t_run r_out_alt;

    // measures of the word in the input register
    lbrt_pkg::t_run run_ones;
    lbrt_pkg::t_run run_zeros;
    lbrt_pkg::t_run run_alt;
    lbrt_pkg::t_run fold_ones;
    lbrt_pkg::t_run fold_zeros;
    lbrt_pkg::t_run fold_alt;
    logic [WORD_BITS-1:0] alt_vec;

    logic out_free;
    logic in_fire;
    logic stage_fire;

    // fit the 32-bit port to the working width
    if (WORD_BITS > lbrt_pkg::IN_W) begin : g_wide
        assign w_ext = {{(WORD_BITS - lbrt_pkg::IN_W){1'b0}}, i_word};
    end else if (WORD_BITS == lbrt_pkg::IN_W) begin : g_same
        assign w_ext = i_word;
    end else begin : g_narrow
        assign w_ext = i_word[WORD_BITS-1:0];
    end

    // handshake: a non-last word never needs the result register
    assign out_free   = !r_out_valid || i_ready;
    assign stage_fire = r_in_valid && (!r_in_last || out_free);
    assign o_ready    = !r_in_valid || stage_fire;
    assign in_fire    = i_valid && o_ready;

    // three run measures in parallel
    assign alt_vec = r_in_word ^ {r_in_word[WORD_BITS-2:0], 1'b0};

    lbrt_run_len #(.WORD_BITS(WORD_BITS)) u_run_ones (
        .i_vec (r_in_word),
        .o_len (run_ones)
    );

    lbrt_run_len #(.WORD_BITS(WORD_BITS)) u_run_zeros (
        .i_vec (~r_in_word),
        .o_len (run_zeros)
    );

    lbrt_run_len #(.WORD_BITS(WORD_BITS)) u_run_alt (
        .i_vec (alt_vec),
        .o_len (run_alt)
    );

    // fold this word into the running maxima
    assign fold_ones  = (run_ones  > r_best_ones)  ? run_ones  : r_best_ones;
    assign fold_zeros = (run_zeros > r_best_zeros) ? run_zeros : r_best_zeros;
    assign fold_alt   = (run_alt   > r_best_alt)   ? run_alt   : r_best_alt;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (stage_fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_best_ones  = r_best_ones;
        n_best_zeros = r_best_zeros;
        n_best_alt   = r_best_alt;
        if (stage_fire) begin
            // last word of a set restarts the maxima
            n_best_ones  = r_in_last ? '0 : fold_ones;
            n_best_zeros = r_in_last ? '0 : fold_zeros;
            n_best_alt   = r_in_last ? '0 : fold_alt;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (stage_fire && r_in_last) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_best_ones  <= '0;
            r_best_zeros <= '0;
            r_best_alt   <= '0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
            r_best_ones  <= n_best_ones;
            r_best_zeros <= n_best_zeros;
            r_best_alt   <= n_best_alt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_word <= w_ext;
            r_in_last <= i_last;
        end
        if (stage_fire && r_in_last) begin
            r_out_ones  <= fold_ones;
            r_out_zeros <= fold_zeros;
            r_out_alt   <= fold_alt;
        end
    end

    // result ports; display words decoded from the result register
    assign o_valid           = r_out_valid;
    assign o_max_ones        = r_out_ones;
    assign o_max_zeros       = r_out_zeros;
    assign o_max_alternating = r_out_alt;
    assign o_display_pair    = {lbrt_pkg::disp_word(r_out_zeros),
                                lbrt_pkg::disp_word(r_out_ones)};
    assign o_display_alt     = lbrt_pkg::disp_word(r_out_alt);

endmodule
